### hdl/vector_sensor_aggregator_unit_defines.svh
// ----------------------------------------------------------------------------
// vector sensor aggregator assertion macros
// shared property shapes for the port checker
// ----------------------------------------------------------------------------
`ifndef VECTOR_SENSOR_AGGREGATOR_UNIT_DEFINES_SVH
`define VECTOR_SENSOR_AGGREGATOR_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define VSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define VSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/vsa_pkg.sv
// ----------------------------------------------------------------------------
// vsa_pkg
// types and constants shared by the vector sensor aggregator modules
// ----------------------------------------------------------------------------
package vsa_pkg;

  localparam int unsigned NUM_PORTS = 8;   // sample ports on the top level
  localparam int unsigned SMP_W     = 16;
  localparam int unsigned LANE_W    = 3;   // element position inside one item
  localparam int unsigned POS_W     = 8;
  localparam int unsigned CNT_W     = 4;   // qualifying element count, up to 8
  localparam int unsigned SUM_W     = SMP_W + LANE_W;
  localparam int unsigned STAT_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;
  localparam int unsigned STEP_W    = 5;
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(SUM_W - 1);

  localparam logic [SMP_W-1:0] SMP_MAX    = '1;
  localparam logic [SMP_W-1:0] SMP_MIN    = '0;
  localparam logic [POS_W-1:0] NO_POS     = '1;

  typedef enum logic [1:0] {
    OP_MIN    = 2'd0,
    OP_MAX    = 2'd1,
    OP_AVG    = 2'd2,
    OP_DIRECT = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OPERATION = 2'd0,
    REG_ELEM_CNT  = 2'd1,
    REG_EN_MASK   = 2'd2,
    REG_AVG_THR   = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MERGE,
    ST_START,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [SMP_W-1:0] value;
    logic             min_ok;
    logic             max_ok;
    logic             avg_ok;
  } lane_t;

  typedef struct packed {
    logic              min_found;
    logic [SMP_W-1:0]  min_value;
    logic [LANE_W-1:0] min_pos;
    logic              max_found;
    logic [SMP_W-1:0]  max_value;
    logic [LANE_W-1:0] max_pos;
    logic [SUM_W-1:0]  avg_sum;
    logic [CNT_W-1:0]  avg_cnt;
  } merge_t;

endpackage

### hdl/vsa_lane.sv
// ----------------------------------------------------------------------------
// vsa_lane
// one element lane: holds the sample and flags what it qualifies for
// ----------------------------------------------------------------------------
module vsa_lane (
  input  logic                       clk_i,
  input  logic                       load_i,
  input  logic [vsa_pkg::SMP_W-1:0]  sample_i,
  input  logic                       active_i,
  input  logic [vsa_pkg::SMP_W-1:0]  threshold_i,
  output vsa_pkg::lane_t             lane_o
);

  logic [vsa_pkg::SMP_W-1:0] value_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      value_q <= sample_i;
    end
  end

  // a sample equal to the search start value never wins a strict compare
  always_comb begin
    lane_o.value  = value_q;
    lane_o.min_ok = active_i && (value_q != vsa_pkg::SMP_MAX);
    lane_o.max_ok = active_i && (value_q != vsa_pkg::SMP_MIN);
    lane_o.avg_ok = active_i && (value_q > threshold_i);
  end

endmodule

### hdl/vsa_merge.sv
// ----------------------------------------------------------------------------
// vsa_merge
// combines the lane flags into first minimum, first maximum and average terms
// ----------------------------------------------------------------------------
module vsa_merge #(
  parameter int unsigned NUM_LANES = 8
) (
  input  logic           clk_i,
  input  logic           capture_i,
  input  vsa_pkg::lane_t lanes_i [NUM_LANES],
  output vsa_pkg::merge_t merge_o
);

  vsa_pkg::merge_t merge_d;
  vsa_pkg::merge_t merge_q;

  // lower lane wins ties, so later lanes need a strictly better value
  always_comb begin
    merge_d = '0;
    merge_d.min_value = vsa_pkg::SMP_MAX;
    for (int i = 0; i < NUM_LANES; i++) begin
      if (lanes_i[i].min_ok && (!merge_d.min_found ||
          (lanes_i[i].value < merge_d.min_value))) begin
        merge_d.min_found = 1'b1;
        merge_d.min_value = lanes_i[i].value;
        merge_d.min_pos   = vsa_pkg::LANE_W'(i);
      end
      if (lanes_i[i].max_ok && (!merge_d.max_found ||
          (lanes_i[i].value > merge_d.max_value))) begin
        merge_d.max_found = 1'b1;
        merge_d.max_value = lanes_i[i].value;
        merge_d.max_pos   = vsa_pkg::LANE_W'(i);
      end
      if (lanes_i[i].avg_ok) begin
        merge_d.avg_sum = merge_d.avg_sum + vsa_pkg::SUM_W'(lanes_i[i].value);
        merge_d.avg_cnt = merge_d.avg_cnt + vsa_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture_i) begin
      merge_q <= merge_d;
    end
  end

  assign merge_o = merge_q;

endmodule

### hdl/vsa_div.sv
// ----------------------------------------------------------------------------
// vsa_div
// restoring divider, one quotient bit a cycle, for the thresholded mean
// ----------------------------------------------------------------------------
module vsa_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [vsa_pkg::SUM_W-1:0]  dividend_i,
  input  logic [vsa_pkg::CNT_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [vsa_pkg::SUM_W-1:0]  quotient_o
);

  logic                        busy_q;
  logic [vsa_pkg::STEP_W-1:0]  step_q;
  logic [vsa_pkg::SUM_W-1:0]   quo_q, quo_d;
  logic [vsa_pkg::CNT_W-1:0]   rem_q, rem_d;
  logic [vsa_pkg::CNT_W-1:0]   div_q;
  logic [vsa_pkg::CNT_W:0]     trial;
  logic                        fits;

  always_comb begin
    trial = {rem_q, quo_q[vsa_pkg::SUM_W-1]};
    fits  = trial >= {1'b0, div_q};
    rem_d = fits ? vsa_pkg::CNT_W'(trial - {1'b0, div_q}) : vsa_pkg::CNT_W'(trial);
    quo_d = {quo_q[vsa_pkg::SUM_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + vsa_pkg::STEP_W'(1);
      if (step_q == vsa_pkg::DIV_LAST) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = busy_q && (step_q == vsa_pkg::DIV_LAST);
  assign quotient_o = quo_q;

endmodule

### hdl/vector_sensor_aggregator_unit.sv
// ----------------------------------------------------------------------------
// vector_sensor_aggregator_unit
// reduces up to eight element samples to one sensor value and keeps statistics
// ----------------------------------------------------------------------------
// One item is taken at a time. Minimum, maximum and direct items skip the
// divider; thresholded average items also pass the 19-step serial divider
// that forms the mean. Each element has its own lane that holds the sample
// and flags whether it takes part; a merge stage picks the first strict
// minimum and maximum and sums the samples above threshold. A result sits in
// an output register, so the next input transfer is taken while that result
// waits. Configuration is written through cfg_* with cfg_ready_o always high;
// write it only while no item is in flight.
module vector_sensor_aggregator_unit #(
  parameter int unsigned NUM_ELEMENTS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [vsa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [vsa_pkg::CFG_DAT_W-1:0]  cfg_data_i,
  // input items
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [vsa_pkg::SMP_W-1:0]      sample_0_i,
  input  logic [vsa_pkg::SMP_W-1:0]      sample_1_i,
  input  logic [vsa_pkg::SMP_W-1:0]      sample_2_i,
  input  logic [vsa_pkg::SMP_W-1:0]      sample_3_i,
  input  logic [vsa_pkg::SMP_W-1:0]      sample_4_i,
  input  logic [vsa_pkg::SMP_W-1:0]      sample_5_i,
  input  logic [vsa_pkg::SMP_W-1:0]      sample_6_i,
  input  logic [vsa_pkg::SMP_W-1:0]      sample_7_i,
  input  logic                           clear_stats_i,
  // result items
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           updated_o,
  output logic [vsa_pkg::SMP_W-1:0]      value_o,
  output logic [vsa_pkg::POS_W-1:0]      min_position_o,
  output logic [vsa_pkg::POS_W-1:0]      max_position_o,
  output logic [vsa_pkg::SMP_W-1:0]      stat_min_o,
  output logic [vsa_pkg::SMP_W-1:0]      stat_max_o,
  output logic [vsa_pkg::STAT_W-1:0]     accumulator_o,
  output logic [vsa_pkg::STAT_W-1:0]     update_seq_o
);

  localparam logic [vsa_pkg::CNT_W-1:0] NumElem = vsa_pkg::CNT_W'(NUM_ELEMENTS);

  // configuration registers
  vsa_pkg::op_e               op_q;
  logic [vsa_pkg::CNT_W-1:0]  elem_cnt_q;
  logic [NUM_ELEMENTS-1:0]    en_mask_q;
  logic [vsa_pkg::SMP_W-1:0]  avg_thr_q;

  // statistics state
  logic                       pending_q;
  logic [vsa_pkg::SMP_W-1:0]  cur_q;
  logic [vsa_pkg::SMP_W-1:0]  rmin_q;
  logic [vsa_pkg::SMP_W-1:0]  rmax_q;
  logic [vsa_pkg::STAT_W-1:0] sum_q;
  logic [vsa_pkg::STAT_W-1:0] tag_q;
  logic [vsa_pkg::POS_W-1:0]  min_idx_q;
  logic [vsa_pkg::POS_W-1:0]  max_idx_q;

  // item control
  vsa_pkg::state_e            state_q, state_d;
  logic                       clear_q;
  logic                       load;
  logic                       capture;
  logic                       div_start;
  logic                       commit;
  logic                       out_free;

  logic [vsa_pkg::SMP_W-1:0]  samples [vsa_pkg::NUM_PORTS];
  logic [vsa_pkg::CNT_W-1:0]  cnt_sat;
  logic [NUM_ELEMENTS-1:0]    active;
  vsa_pkg::lane_t             lanes [NUM_ELEMENTS];
  vsa_pkg::merge_t            merge;
  logic                       div_done;
  logic [vsa_pkg::SUM_W-1:0]  quotient;

  // commit values
  logic                       upd;
  logic [vsa_pkg::SMP_W-1:0]  v;
  logic [vsa_pkg::SMP_W-1:0]  cur_d, rmin_d, rmax_d;
  logic [vsa_pkg::STAT_W-1:0] sum_d, tag_d;
  logic [vsa_pkg::POS_W-1:0]  min_idx_d, max_idx_d;

  // ---------------------------------------------------------------------------
  // configuration port, always ready
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q       <= vsa_pkg::OP_MIN;
      elem_cnt_q <= '0;
      en_mask_q  <= '0;
      avg_thr_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        vsa_pkg::REG_OPERATION: op_q       <= vsa_pkg::op_e'(cfg_data_i[1:0]);
        vsa_pkg::REG_ELEM_CNT:  elem_cnt_q <= cfg_data_i[vsa_pkg::CNT_W-1:0];
        vsa_pkg::REG_EN_MASK:   en_mask_q  <= cfg_data_i[NUM_ELEMENTS-1:0];
        vsa_pkg::REG_AVG_THR:   avg_thr_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // element lanes
  // ---------------------------------------------------------------------------
  assign samples[0] = sample_0_i;
  assign samples[1] = sample_1_i;
  assign samples[2] = sample_2_i;
  assign samples[3] = sample_3_i;
  assign samples[4] = sample_4_i;
  assign samples[5] = sample_5_i;
  assign samples[6] = sample_6_i;
  assign samples[7] = sample_7_i;

  // counts past the lane number saturate
  assign cnt_sat = (elem_cnt_q > NumElem) ? NumElem : elem_cnt_q;

  for (genvar g = 0; g < NUM_ELEMENTS; g++) begin : g_lane
    assign active[g] = en_mask_q[g] && (vsa_pkg::CNT_W'(g) < cnt_sat);

    vsa_lane u_lane (
      .clk_i       (clk_i),
      .load_i      (load),
      .sample_i    (samples[g]),
      .active_i    (active[g]),
      .threshold_i (avg_thr_q),
      .lane_o      (lanes[g])
    );
  end

  // ---------------------------------------------------------------------------
  // merge stage and divider
  // ---------------------------------------------------------------------------
  vsa_merge #(
    .NUM_LANES (NUM_ELEMENTS)
  ) u_merge (
    .clk_i     (clk_i),
    .capture_i (capture),
    .lanes_i   (lanes),
    .merge_o   (merge)
  );

  vsa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (merge.avg_sum),
    .divisor_i  (merge.avg_cnt),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // ---------------------------------------------------------------------------
  // item sequencer
  // ---------------------------------------------------------------------------
  assign out_free = !out_valid_o || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vsa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    load       = 1'b0;
    capture    = 1'b0;
    div_start  = 1'b0;
    commit     = 1'b0;
    case (state_q)
      vsa_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        load       = in_valid_i;
        if (in_valid_i) begin
          state_d = vsa_pkg::ST_MERGE;
        end
      end
      vsa_pkg::ST_MERGE: begin
        capture = 1'b1;
        state_d = vsa_pkg::ST_START;
      end
      vsa_pkg::ST_START: begin
        if (op_q == vsa_pkg::OP_AVG) begin
          div_start = 1'b1;
          state_d   = vsa_pkg::ST_DIV;
        end else begin
          state_d   = vsa_pkg::ST_DONE;
        end
      end
      vsa_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = vsa_pkg::ST_DONE;
        end
      end
      vsa_pkg::ST_DONE: begin
        // wait for room in the output register
        if (out_free) begin
          commit  = 1'b1;
          state_d = vsa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = vsa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      clear_q <= clear_stats_i;
    end
  end

  // ---------------------------------------------------------------------------
  // statistics update
  // ---------------------------------------------------------------------------
  always_comb begin
    // a pending or requested clear comes first; the update count survives it
    if (pending_q || clear_q) begin
      cur_d     = '0;
      rmin_d    = vsa_pkg::SMP_MAX;
      rmax_d    = vsa_pkg::SMP_MIN;
      sum_d     = '0;
      min_idx_d = vsa_pkg::NO_POS;
      max_idx_d = vsa_pkg::NO_POS;
    end else begin
      cur_d     = cur_q;
      rmin_d    = rmin_q;
      rmax_d    = rmax_q;
      sum_d     = sum_q;
      min_idx_d = min_idx_q;
      max_idx_d = max_idx_q;
    end
    tag_d = tag_q;

    // the reduced value; the min position is written on minimum items, the max position on maximum items
    case (op_q)
      vsa_pkg::OP_MIN: begin
        v         = merge.min_found ? merge.min_value : vsa_pkg::SMP_MAX;
        min_idx_d = merge.min_found ? vsa_pkg::POS_W'(merge.min_pos) : '0;
        upd       = merge.min_found;
      end
      vsa_pkg::OP_MAX: begin
        v         = merge.max_found ? merge.max_value : vsa_pkg::SMP_MIN;
        max_idx_d = merge.max_found ? vsa_pkg::POS_W'(merge.max_pos) : '0;
        upd       = merge.max_found;
      end
      vsa_pkg::OP_AVG: begin
        // no qualifying sample gives a zero mean
        v   = (merge.avg_cnt != '0) ? quotient[vsa_pkg::SMP_W-1:0] : '0;
        upd = (v != '0);
      end
      default: begin
        v   = lanes[0].value;
        upd = 1'b1;
      end
    endcase

    if (upd) begin
      cur_d = v;
      if (v < rmin_d) begin
        rmin_d = v;
      end
      if (v > rmax_d) begin
        rmax_d = v;
      end
      sum_d = sum_d + vsa_pkg::STAT_W'(v);
      tag_d = tag_q + vsa_pkg::STAT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b1;
      cur_q     <= '0;
      rmin_q    <= vsa_pkg::SMP_MAX;
      rmax_q    <= vsa_pkg::SMP_MIN;
      sum_q     <= '0;
      tag_q     <= '0;
      min_idx_q <= vsa_pkg::NO_POS;
      max_idx_q <= vsa_pkg::NO_POS;
    end else if (commit) begin
      pending_q <= 1'b0;
      cur_q     <= cur_d;
      rmin_q    <= rmin_d;
      rmax_q    <= rmax_d;
      sum_q     <= sum_d;
      tag_q     <= tag_d;
      min_idx_q <= min_idx_d;
      max_idx_q <= max_idx_d;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (commit) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      updated_o      <= upd;
      value_o        <= cur_d;
      min_position_o <= min_idx_d;
      max_position_o <= max_idx_d;
      stat_min_o     <= rmin_d;
      stat_max_o     <= rmax_d;
      accumulator_o  <= sum_d;
      update_seq_o   <= tag_d;
    end
  end

endmodule

### hdl/vsa_checker.sv
// ----------------------------------------------------------------------------
// vsa_port_checker
// port-level checks for the vector sensor aggregator, bound to the top level
// ----------------------------------------------------------------------------
`include "vector_sensor_aggregator_unit_defines.svh"

module vsa_port_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic                           updated_o,
  input logic [vsa_pkg::SMP_W-1:0]      value_o,
  input logic [vsa_pkg::SMP_W-1:0]      stat_min_o,
  input logic [vsa_pkg::SMP_W-1:0]      stat_max_o,
  input logic [vsa_pkg::STAT_W-1:0]     update_seq_o
);

  // one item at a time: an input transfer closes the input side
  `VSA_ASSERT_NEXT(a_one_item, in_valid_i && !in_stall_o, in_stall_o, "input taken while busy")

  // a fresh sample always lies within the running range
  `VSA_ASSERT_NOW(a_value_in_range, out_valid_o && updated_o,
    (value_o >= stat_min_o) && (value_o <= stat_max_o), "sample outside min/max")

  // a stalled result holds
  `VSA_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(value_o) && $stable(update_seq_o), "stalled result changed")

endmodule

bind vector_sensor_aggregator_unit vsa_port_checker u_vsa_checker (.*);
